// ----- src/tpa_pkg.sv -----
`timescale 1ns / 1ps

package tpa_pkg;

   // Pool geometry and field widths.
   localparam int PoolSize  = 1024;
   localparam int SlotW     = $clog2(PoolSize);
   localparam int CountW    = $clog2(PoolSize + 1);
   localparam int FrameW    = 32;
   localparam int LifeW     = 16;
   localparam int CmdW      = 2;
   localparam int CsrAddrW  = 3;
   localparam int CsrDataW  = 32;

   localparam logic [LifeW-1:0]    LifeReset   = LifeW'(300);
   localparam logic [CsrAddrW-1:0] AddrLifetime = CsrAddrW'(0);

   // Command codes.
   localparam logic [CmdW-1:0] CmdAlloc   = 2'd0;
   localparam logic [CmdW-1:0] CmdRelease = 2'd1;
   localparam logic [CmdW-1:0] CmdTick    = 2'd2;

   typedef struct packed {
      logic [CmdW-1:0]  command;
      logic [SlotW-1:0] slot_index;
   } req_word_type;

   typedef struct packed {
      logic              ok;
      logic [SlotW-1:0]  granted_slot;
      logic [CountW-1:0] expired_count;
      logic [CountW-1:0] active_count;
   } rsp_word_type;

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_EXEC     = 6'b000100,
      ST_TICK_RD  = 6'b001000,
      ST_TICK_CHK = 6'b010000,
      ST_TICK_END = 6'b100000
   } state_type;

endpackage

// ----- src/timed_object_pool_allocator_core.sv -----
`timescale 1ns / 1ps

// Allocate, release and unused codes: ST_EXEC writes the result once the result register is free.
// A tick reads the order-list head (ST_TICK_RD), checks it (ST_TICK_CHK) and repeats for
// every slot it expires, then writes the result in ST_TICK_END; with no slot active it
// skips the check. One item is in work at a time; the result register lets the next item
// enter while it waits. Reset clears control state, then a pass clears all 1024 slot
// memory entries; no request word is taken during that pass.
module timed_object_pool_allocator_core
   import tpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_word_type        req_word,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_word_type        rsp_word,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready
);

   // Memories: free list, slot state {active, start frame}, order-list links.
   logic [SlotW-1:0]  fifo_mem [PoolSize];
   logic [FrameW:0]   slot_mem [PoolSize];
   logic [SlotW-1:0]  nxt_mem  [PoolSize];
   logic [SlotW-1:0]  prv_mem  [PoolSize];

   state_type         state_ff, state_in;
   logic [SlotW-1:0]  clr_ff, clr_in;
   logic [SlotW-1:0]  head_ff, head_in;
   logic [SlotW-1:0]  tail_ff, tail_in;
   logic              wrapped_ff, wrapped_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [SlotW-1:0]  ohead_ff, ohead_in;
   logic [SlotW-1:0]  otail_ff, otail_in;
   logic [FrameW-1:0] frame_ff, frame_in;
   logic [LifeW-1:0]  life_ff;
   logic [CmdW-1:0]   cmd_ff, cmd_in;
   logic [SlotW-1:0]  idx_ff, idx_in;
   logic [CountW-1:0] exp_ff, exp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;

   // Registered read data.
   logic [SlotW-1:0]  fifo_rd_ff;
   logic              fifo_ok_ff;
   logic [FrameW:0]   slot_rd_ff;
   logic [SlotW-1:0]  nxt_rd_ff;
   logic [SlotW-1:0]  prv_rd_ff;

   logic              accept, out_free, rd_en;
   logic [SlotW-1:0]  rd_addr;
   logic              slot_we, nxt_we, prv_we, fifo_we;
   logic [SlotW-1:0]  slot_wa, nxt_wa, prv_wa, fifo_wa;
   logic [FrameW:0]   slot_wd;
   logic [SlotW-1:0]  nxt_wd, prv_wd, fifo_wd;
   logic [SlotW-1:0]  alloc_slot;
   logic [FrameW-1:0] age;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Configuration port.
   assign pready = 1'b1;
   assign prdata = (paddr == AddrLifetime) ? CsrDataW'(life_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         life_ff <= LifeReset;
      end else if (psel && penable && pwrite && pready && paddr == AddrLifetime) begin
         life_ff <= pwdata[LifeW-1:0];
      end
   end

   // Read side: the request's slot on acceptance, the order-list head during a tick.
   assign rd_en   = accept || (state_ff == ST_TICK_RD);
   assign rd_addr = (state_ff == ST_TICK_RD) ? ohead_ff : req_word.slot_index;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fifo_rd_ff <= fifo_mem[head_ff];
         fifo_ok_ff <= wrapped_ff || (head_ff < tail_ff);
         slot_rd_ff <= slot_mem[rd_addr];
         nxt_rd_ff  <= nxt_mem[rd_addr];
         prv_rd_ff  <= prv_mem[rd_addr];
      end
   end

   // Write side.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (nxt_we) begin
         nxt_mem[nxt_wa] <= nxt_wd;
      end
      if (prv_we) begin
         prv_mem[prv_wa] <= prv_wd;
      end
      if (fifo_we) begin
         fifo_mem[fifo_wa] <= fifo_wd;
      end
   end

   // Entries of the free list never written since reset are not read: the head index stands in for them.
   assign alloc_slot = fifo_ok_ff ? fifo_rd_ff : head_ff;
   assign age        = frame_ff - slot_rd_ff[FrameW-1:0];

   // Sequencer and state updates.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      wrapped_in   = wrapped_ff;
      count_in     = count_ff;
      ohead_in     = ohead_ff;
      otail_in     = otail_ff;
      frame_in     = frame_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      exp_in       = exp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      slot_we      = 1'b0;
      slot_wa      = idx_ff;
      slot_wd      = '0;
      nxt_we       = 1'b0;
      nxt_wa       = prv_rd_ff;
      nxt_wd       = nxt_rd_ff;
      prv_we       = 1'b0;
      prv_wa       = nxt_rd_ff;
      prv_wd       = prv_rd_ff;
      fifo_we      = 1'b0;
      fifo_wa      = tail_ff;
      fifo_wd      = idx_ff;

      case (state_ff)
         ST_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_ff;
            clr_in  = SlotW'(clr_ff + 1'b1);
            if (clr_ff == SlotW'(PoolSize - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_word.command;
               idx_in = req_word.slot_index;
               exp_in = '0;
               if (req_word.command == CmdTick) begin
                  frame_in = frame_ff + 1'b1;
                  state_in = ST_TICK_RD;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_in.ok            = 1'b0;
               rsp_in.granted_slot  = idx_ff;
               rsp_in.expired_count = '0;
               if (cmd_ff == CmdAlloc && count_ff != '0) begin
                  // Pop the free list and append to the allocation order.
                  head_in  = SlotW'(head_ff + 1'b1);
                  count_in = count_ff - 1'b1;
                  slot_we  = 1'b1;
                  slot_wa  = alloc_slot;
                  slot_wd  = {1'b1, frame_ff};
                  if (count_ff == CountW'(PoolSize)) begin
                     ohead_in = alloc_slot;
                  end else begin
                     nxt_we = 1'b1;
                     nxt_wa = otail_ff;
                     nxt_wd = alloc_slot;
                  end
                  prv_we   = 1'b1;
                  prv_wa   = alloc_slot;
                  prv_wd   = otail_ff;
                  otail_in = alloc_slot;
                  rsp_in.ok           = 1'b1;
                  rsp_in.granted_slot = alloc_slot;
               end else if (cmd_ff == CmdRelease && slot_rd_ff[FrameW]) begin
                  // Unlink from the order list and push onto the free list.
                  if (idx_ff == ohead_ff) begin
                     ohead_in = nxt_rd_ff;
                  end else begin
                     nxt_we = 1'b1;
                  end
                  if (idx_ff == otail_ff) begin
                     otail_in = prv_rd_ff;
                  end else begin
                     prv_we = 1'b1;
                  end
                  slot_we  = 1'b1;
                  fifo_we  = 1'b1;
                  tail_in  = SlotW'(tail_ff + 1'b1);
                  if (tail_ff == SlotW'(PoolSize - 1)) begin
                     wrapped_in = 1'b1;
                  end
                  count_in  = count_ff + 1'b1;
                  rsp_in.ok = 1'b1;
               end
               rsp_in.active_count = CountW'(PoolSize) - count_in;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            if (count_ff == CountW'(PoolSize)) begin
               state_in = ST_TICK_END;
            end else begin
               state_in = ST_TICK_CHK;
            end
         end
         ST_TICK_CHK: begin
            // Expiry is a prefix of the allocation order: stop at the first young slot.
            if (age >= FrameW'(life_ff)) begin
               slot_we  = 1'b1;
               slot_wa  = ohead_ff;
               fifo_we  = 1'b1;
               fifo_wd  = ohead_ff;
               tail_in  = SlotW'(tail_ff + 1'b1);
               if (tail_ff == SlotW'(PoolSize - 1)) begin
                  wrapped_in = 1'b1;
               end
               count_in = count_ff + 1'b1;
               exp_in   = exp_ff + 1'b1;
               ohead_in = nxt_rd_ff;
               state_in = ST_TICK_RD;
            end else begin
               state_in = ST_TICK_END;
            end
         end
         ST_TICK_END: begin
            if (out_free) begin
               rsp_in.ok            = 1'b1;
               rsp_in.granted_slot  = idx_ff;
               rsp_in.expired_count = exp_ff;
               rsp_in.active_count  = CountW'(PoolSize) - count_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wrapped_ff   <= 1'b0;
         count_ff     <= CountW'(PoolSize);
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wrapped_ff   <= wrapped_in;
         count_ff     <= count_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ohead_ff <= ohead_in;
      otail_ff <= otail_in;
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      exp_ff   <= exp_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// ----- src/tpa_checker.sv -----
`timescale 1ns / 1ps

module tpa_checker
   import tpa_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // The clearing pass keeps requests out right after reset.
   a_clear: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // One item at a time: no request right after one is taken.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken back to back");

   // Expired slots are only reported by a successful tick.
   a_expired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.expired_count != '0 |-> rsp_word.ok)
      else $error("expired count without success");

   // The active count never exceeds the pool.
   a_active_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.active_count <= CountW'(PoolSize))
      else $error("active count out of range");

endmodule

bind timed_object_pool_allocator_core tpa_checker u_tpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
